@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define AMDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define AMDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/amdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package amdc_pkg;

    localparam int unsigned RES_W   = 28;
    localparam int unsigned EQ_W    = 19;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned GAIN_W  = 16;

    localparam int unsigned IN_TDATA_W  = 96;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 19;

    // Product gain * |error| * 100 and the quotient after the Q8 shift.
    localparam int unsigned PROD_W  = 50;
    localparam int unsigned DIV_DW  = PROD_W - 8;
    localparam int unsigned DIV_VW  = EQ_W;

    localparam int unsigned EXTRA_GAIN_Q8_DEF = 0;

    localparam logic [EQ_W-1:0]  MAX_MOTOR_EQ = 19'd500000;
    localparam logic [DUR_W-1:0] ISSUE_MIN_CS = 16'd10;

    typedef logic [DUR_W-1:0] t_dur;
    typedef logic [EQ_W-1:0]  t_eq;

endpackage

`default_nettype wire

@@ rtl/amdc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module amdc_div #(
    parameter int unsigned DW = amdc_pkg::DIV_DW,
    parameter int unsigned VW = amdc_pkg::DIV_VW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);
    import amdc_pkg::*;

    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [VW-1:0]    r_dvs;

    logic [VW:0]      w_sh;
    logic [VW:0]      w_diff;

    // Restoring division, one quotient bit per cycle, most significant first.
    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_diff = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[VW]) begin
                r_rem <= w_diff[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ rtl/anode_move_duration_calc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Works out the direction and length of one anode move per item from the signed
// resistance error, and learns the lowering motor equivalent from the resistance
// change after each issued move. One item is in flight at a time: a raising item,
// or a lowering item with no adaptation due, is offered as a result after a 16-step
// bit-serial gain multiply, a 42-step restoring divider and, with a nonzero extra
// gain, an extra-gain scaling state. A lowering item with adaptation due runs the
// same divider once more for the resistance rate first. The input opens again in
// the same cycle as the result is offered. A finished result waits in the output
// register while the next item is already being taken in; an item that finishes
// while that register is still full holds, and keeps the input closed.
module anode_move_duration_calc_core #(
    parameter int unsigned EXTRA_GAIN_Q8 = amdc_pkg::EXTRA_GAIN_Q8_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // resistance_error[27:0], cycle_resistance[55:28], motor_eq_lower[74:56],
    // motor_eq_raise[93:75], zero fill above
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [amdc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // move_duration[15:0], adapted_motor_eq[34:16], zero fill above
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [amdc_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // direction[0], move_issued[1]
    output logic [amdc_pkg::OUT_TUSER_W-1:0]         m_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [amdc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [amdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import amdc_pkg::*;

    localparam logic [GAIN_W-1:0] XG = GAIN_W'(EXTRA_GAIN_Q8);
    localparam int unsigned MCAND_W = RES_W + 7;
    localparam int unsigned GCNT_W  = $clog2(GAIN_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOWER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RAISE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_LOWER_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_LOWER_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_RAISE_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_RAISE_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOTOR_EQ  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_ENABLE  = 3'd7;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADIFF     = 4'd1;
    localparam logic [3:0] S_ADIV_GO   = 4'd2;
    localparam logic [3:0] S_ADIV_WAIT = 4'd3;
    localparam logic [3:0] S_MUL_INIT  = 4'd4;
    localparam logic [3:0] S_MUL       = 4'd5;
    localparam logic [3:0] S_DDIV_GO   = 4'd6;
    localparam logic [3:0] S_DDIV_WAIT = 4'd7;
    localparam logic [3:0] S_XGAIN     = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    function automatic logic [MCAND_W-1:0] f_times100(input logic [RES_W-1:0] v);
        logic [MCAND_W-1:0] e;
        e = MCAND_W'(v);
        return (e << 6) + (e << 5) + (e << 2);
    endfunction

    // Configuration registers.
    logic [GAIN_W-1:0] r_gain_lower;
    logic [GAIN_W-1:0] r_gain_raise;
    t_dur              r_dur_lower_min;
    t_dur              r_dur_lower_max;
    t_dur              r_dur_raise_min;
    t_dur              r_dur_raise_max;
    t_eq               r_min_eq;
    logic              r_adapt_en;

    // Learned state.
    t_eq               r_adapted;
    logic              r_recalc;
    logic [RES_W-1:0]  r_last_res;
    t_dur              r_last_dur;

    // Control.
    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [GCNT_W-1:0] r_gcnt;
    logic              r_out_valid;

    // Item datapath.
    logic              r_neg;
    logic              r_use_adapt;
    logic [RES_W-1:0]  r_mag;
    logic [RES_W-1:0]  r_cyc;
    t_eq               r_eq;
    logic [RES_W-1:0]  r_diff;
    logic [MCAND_W-1:0] r_mcand;
    logic [GAIN_W-1:0] r_gsh;
    logic [PROD_W-1:0] r_acc;
    t_eq               r_dvs;
    t_dur              r_dur;

    t_dur              r_out_dur;
    logic              r_out_dir;
    logic              r_out_iss;
    t_eq               r_out_eq;

    logic [RES_W-1:0]  w_err;
    logic              w_err_neg;
    logic              w_accept;
    logic              w_out_free;
    logic              w_div_start;
    logic [DIV_DW-1:0] w_div_dividend;
    logic [DIV_VW-1:0] w_div_divisor;
    logic              w_div_done;
    logic [DIV_DW-1:0] w_quo;
    logic [DIV_DW:0]   w_sum;
    logic [DIV_DW-1:0] w_avg;
    logic [DIV_DW-1:0] w_avg_lo;
    t_eq               w_new_eq;
    t_eq               w_eq_sel;
    t_dur              w_lo;
    t_dur              w_hi;
    t_dur              w_clamped;
    logic [2*DUR_W-1:0] w_xprod;
    t_dur              w_xdur;
    logic              w_issued;

    assign w_err     = s_tdata[RES_W-1:0];
    assign w_err_neg = w_err[RES_W-1];
    assign s_tready  = (r_state == S_IDLE);
    assign w_accept  = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;
    assign o_cfg_ready = 1'b1;

    assign w_div_start    = (r_state == S_ADIV_GO) || (r_state == S_DDIV_GO);
    assign w_div_dividend = (r_state == S_ADIV_GO) ? DIV_DW'(f_times100(r_diff))
                                                   : r_acc[PROD_W-1:8];
    assign w_div_divisor  = (r_state == S_ADIV_GO)
                          ? ((r_last_dur == '0) ? DIV_VW'(1) : DIV_VW'(r_last_dur))
                          : r_dvs;

    amdc_div #(
        .DW(DIV_DW),
        .VW(DIV_VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // The new equivalent is the mean of the old one and the rate, then clamped.
    assign w_sum    = {1'b0, w_quo} + (DIV_DW + 1)'(r_adapted);
    assign w_avg    = w_sum[DIV_DW:1];
    assign w_avg_lo = (w_avg < DIV_DW'(r_min_eq)) ? DIV_DW'(r_min_eq) : w_avg;
    assign w_new_eq = (w_avg_lo > DIV_DW'(MAX_MOTOR_EQ)) ? MAX_MOTOR_EQ
                                                          : w_avg_lo[EQ_W-1:0];

    assign w_eq_sel = r_use_adapt ? r_adapted : r_eq;
    assign w_lo     = r_neg ? r_dur_lower_min : r_dur_raise_min;
    assign w_hi     = r_neg ? r_dur_lower_max : r_dur_raise_max;
    assign w_clamped = (w_quo < DIV_DW'(w_lo)) ? '0
                     : (w_quo > DIV_DW'(w_hi)) ? w_hi
                     : w_quo[DUR_W-1:0];

    assign w_xprod  = (2*DUR_W)'(r_dur) * (2*DUR_W)'(XG);
    assign w_xdur   = (w_xprod[2*DUR_W-1:8] > (2*DUR_W-8)'({DUR_W{1'b1}}))
                    ? {DUR_W{1'b1}} : w_xprod[DUR_W+7:8];
    assign w_issued = (r_dur >= ISSUE_MIN_CS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_err_neg && r_adapt_en && r_recalc) ? S_ADIFF : S_MUL_INIT;
                end
            end
            S_ADIFF:     n_state = S_ADIV_GO;
            S_ADIV_GO:   n_state = S_ADIV_WAIT;
            S_ADIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_MUL_INIT;
                end
            end
            S_MUL_INIT:  n_state = S_MUL;
            S_MUL: begin
                if (r_gcnt == GCNT_W'(1)) begin
                    n_state = S_DDIV_GO;
                end
            end
            S_DDIV_GO:   n_state = S_DDIV_WAIT;
            S_DDIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (XG != '0) ? S_XGAIN : S_DONE;
                end
            end
            S_XGAIN:     n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_gain_lower    <= 16'd256;
            r_gain_raise    <= 16'd256;
            r_dur_lower_min <= 16'd10;
            r_dur_lower_max <= 16'd1000;
            r_dur_raise_min <= 16'd10;
            r_dur_raise_max <= 16'd1000;
            r_min_eq        <= 19'd1000;
            r_adapt_en      <= 1'b0;
            r_adapted       <= MAX_MOTOR_EQ;
            r_recalc        <= 1'b0;
            r_last_res      <= '0;
            r_last_dur      <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GAIN_LOWER:    r_gain_lower    <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_RAISE:    r_gain_raise    <= i_cfg_data[GAIN_W-1:0];
                    CFG_DUR_LOWER_MIN: r_dur_lower_min <= i_cfg_data[DUR_W-1:0];
                    CFG_DUR_LOWER_MAX: r_dur_lower_max <= i_cfg_data[DUR_W-1:0];
                    CFG_DUR_RAISE_MIN: r_dur_raise_min <= i_cfg_data[DUR_W-1:0];
                    CFG_DUR_RAISE_MAX: r_dur_raise_max <= i_cfg_data[DUR_W-1:0];
                    CFG_MIN_MOTOR_EQ:  r_min_eq        <= i_cfg_data[EQ_W-1:0];
                    CFG_ADAPT_ENABLE:  r_adapt_en      <= i_cfg_data[0];
                endcase
            end

            if ((r_state == S_ADIV_WAIT) && w_div_done) begin
                r_adapted <= w_new_eq;
                r_recalc  <= 1'b0;
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
                if (w_issued) begin
                    r_recalc   <= 1'b1;
                    r_last_dur <= r_dur;
                    r_last_res <= r_cyc;
                end
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg       <= w_err_neg;
            r_use_adapt <= w_err_neg && r_adapt_en;
            r_mag       <= w_err_neg ? RES_W'(~w_err + 1'b1) : w_err;
            r_cyc       <= s_tdata[2*RES_W-1:RES_W];
            r_eq        <= w_err_neg ? s_tdata[2*RES_W+EQ_W-1:2*RES_W]
                                     : s_tdata[2*RES_W+2*EQ_W-1:2*RES_W+EQ_W];
        end

        if (r_state == S_ADIFF) begin
            r_diff <= (r_last_res >= r_cyc) ? (r_last_res - r_cyc) : (r_cyc - r_last_res);
        end

        // Gain bits enter most significant first; the accumulator doubles each step.
        if (r_state == S_MUL_INIT) begin
            r_mcand <= f_times100(r_mag);
            r_gsh   <= r_neg ? r_gain_lower : r_gain_raise;
            r_acc   <= '0;
            r_gcnt  <= GCNT_W'(GAIN_W);
            r_dvs   <= (w_eq_sel == '0) ? EQ_W'(1) : w_eq_sel;
        end else if (r_state == S_MUL) begin
            r_acc  <= (r_acc << 1) + (r_gsh[GAIN_W-1] ? PROD_W'(r_mcand) : '0);
            r_gsh  <= r_gsh << 1;
            r_gcnt <= r_gcnt - 1'b1;
        end

        if ((r_state == S_DDIV_WAIT) && w_div_done) begin
            r_dur <= w_clamped;
        end else if (r_state == S_XGAIN) begin
            r_dur <= w_xdur;
        end

        if ((r_state == S_DONE) && w_out_free) begin
            r_out_dur <= r_dur;
            r_out_dir <= !r_neg;
            r_out_iss <= w_issued;
            r_out_eq  <= r_adapted;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {(OUT_TDATA_W - EQ_W - DUR_W)'(0), r_out_eq, r_out_dur};
    assign m_tuser  = {r_out_iss, r_out_dir};

endmodule

`default_nettype wire

@@ rtl/amdc_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module amdc_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [amdc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic [amdc_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import amdc_pkg::*;

    `AMDC_ASSERT(a_issue_flag, i_clk, i_rst_n, m_tvalid |-> (m_tuser[1] == (m_tdata[DUR_W-1:0] >= ISSUE_MIN_CS)), "move_issued disagrees with the duration")
    `AMDC_ASSERT(a_eq_range, i_clk, i_rst_n, m_tvalid |-> (m_tdata[DUR_W+EQ_W-1:DUR_W] <= MAX_MOTOR_EQ), "adapted equivalent above its maximum")
    `AMDC_ASSERT(a_one_in_flight, i_clk, i_rst_n, (s_tvalid && s_tready) |=> !s_tready, "input taken while an item is in progress")
    `AMDC_ASSERT(a_out_hold, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind anode_move_duration_calc_core amdc_chk u_amdc_chk (.*);

`default_nettype wire
